FILE: rtl/ups_pkg.sv
// Shared types and constants of the UTF-8 path sanitiser.
package ups_pkg;

	// Characters that steer the decoder and the component filter
	localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
	localparam logic [15:0] CH_SLASH      = 16'h002F;
	localparam logic [15:0] CH_BACKSLASH  = 16'h005C;
	localparam logic [15:0] CH_COLON      = 16'h003A;
	localparam logic [15:0] CH_DOT        = 16'h002E;

	// Lead byte classification
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] CODE_LEAD2 = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] CODE_LEAD3 = 8'hE0;

	// Default depth of the decoded-character queue
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// One queue entry: up to two decoded characters and the end-of-name flag
	typedef struct packed {
		logic        c0_vld;
		logic [15:0] c0;
		logic        c1_vld;
		logic [15:0] c1;
		logic        fin;
	} entry_t;

	typedef struct packed {
		logic   vld;
		entry_t ent;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// One result transaction
	typedef struct packed {
		logic [15:0] ch;
		logic        endm;
	} out_item_t;

endpackage

FILE: rtl/ups_fifo.sv
// Small register queue between the decoder and the component filter.
module ups_fifo import ups_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       pop,
	output entry_t     head,
	output fifo_stat_t stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push.vld && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.ent;
		end
	end

endmodule

FILE: rtl/ups_front.sv
// Front end: takes name bytes and decodes UTF-8 into 16-bit characters.
module ups_front import ups_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] name_byte,
	input  logic       final_byte,
	input  fifo_stat_t q_stat,
	output push_t      push
);

	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_ONE  = 2'd1;
	localparam logic [1:0] NEED_TWO  = 2'd2;

	logic [7:0] lead_q, lead_d;
	logic [1:0] need_q, need_d;
	logic [7:0] ffb_q, ffb_d;
	logic       held_q, held_d;
	logic       acc;
	entry_t     ent;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		lead_d = lead_q;
		need_d = need_q;
		ffb_d  = ffb_q;
		held_d = held_q;
		ent    = '0;
		priority if (need_q == NEED_NONE) begin
			priority if (!name_byte[7]) begin
				ent.c0_vld = 1'b1;
				ent.c0     = {8'h00, name_byte};
			end else if ((name_byte & MASK_LEAD2) == CODE_LEAD2 && !final_byte) begin
				lead_d = name_byte;
				need_d = NEED_ONE;
				held_d = 1'b0;
			end else if ((name_byte & MASK_LEAD3) == CODE_LEAD3 && !final_byte) begin
				lead_d = name_byte;
				need_d = NEED_TWO;
				held_d = 1'b0;
			end else begin
				ent.c0_vld = 1'b1;
				ent.c0     = CH_UNDERSCORE;
			end
		end else if (need_q == NEED_TWO) begin
			if (final_byte) begin
				// cut-short 3-byte lead; the byte is retried as a fresh final byte
				ent.c0_vld = 1'b1;
				ent.c0     = CH_UNDERSCORE;
				ent.c1_vld = 1'b1;
				ent.c1     = name_byte[7] ? CH_UNDERSCORE : {8'h00, name_byte};
				need_d     = NEED_NONE;
			end else begin
				ffb_d  = name_byte;
				held_d = 1'b1;
				need_d = NEED_ONE;
			end
		end else begin
			ent.c0_vld = 1'b1;
			ent.c0     = held_q ? {lead_q[3:0], ffb_q[5:0], name_byte[5:0]}
			                    : {5'b0, lead_q[4:0], name_byte[5:0]};
			need_d     = NEED_NONE;
			held_d     = 1'b0;
		end
		if (final_byte) begin
			ent.fin = 1'b1;
			lead_d  = '0;
			need_d  = NEED_NONE;
			ffb_d   = '0;
			held_d  = 1'b0;
		end
	end

	assign push.vld = acc && (ent.c0_vld || ent.fin);
	assign push.ent = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			need_q <= NEED_NONE;
			ffb_q  <= '0;
			held_q <= 1'b0;
		end else if (acc) begin
			lead_q <= lead_d;
			need_q <= need_d;
			ffb_q  <= ffb_d;
			held_q <= held_d;
		end
	end

endmodule

FILE: rtl/ups_back.sv
// Back end: component filter and result sequencer with output register.
module ups_back import ups_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  fifo_stat_t  q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] path_char,
	output logic        end_mark
);

	localparam out_item_t END_ITEM = '{ch: 16'h0000, endm: 1'b1};
	localparam out_item_t BS_ITEM  = '{ch: CH_BACKSLASH, endm: 1'b0};

	logic [1:0]  len_q;
	logic [15:0] held0_q, held1_q;
	logic        kept_q;
	logic [1:0]  idx_q;
	logic [2:0]  done_q;
	logic        out_vld_q;
	out_item_t   out_q;

	logic [2:0]  pend, cur;
	logic [15:0] ch;
	logic        is_sep, keep1, keep2;
	out_item_t   body [4];
	logic [2:0]  body_n, n;
	logic        need_bs;
	out_item_t   sel;
	logic        active, load_ok, step, emit, last, ev_done, ent_done;

	always_comb begin
		pend = {head.fin, head.c1_vld, head.c0_vld} & ~done_q & {3{!q_stat.empty}};
		cur  = pend & (~pend + 3'd1);
		ch   = cur[0] ? head.c0 : head.c1;
		is_sep = (ch == CH_SLASH) || (ch == CH_BACKSLASH);
		keep1  = (len_q == 2'd1) && (held0_q != CH_DOT);
		keep2  = (len_q == 2'd2) &&
		         !(((held0_q == CH_DOT) && (held1_q == CH_DOT)) || (held1_q == CH_COLON));
		for (int i = 0; i < 4; i++) begin
			body[i] = END_ITEM;
		end
		body_n  = 3'd0;
		need_bs = 1'b0;
		if (cur[2]) begin
			// end of name: close open component, then the end marker
			priority if (keep1) begin
				body[0] = '{ch: held0_q, endm: 1'b0};
				body_n  = 3'd2;
				need_bs = kept_q;
			end else if (keep2) begin
				body[0] = '{ch: held0_q, endm: 1'b0};
				body[1] = '{ch: held1_q, endm: 1'b0};
				body_n  = 3'd3;
				need_bs = kept_q;
			end else begin
				body_n = 3'd1;
			end
		end else if (is_sep) begin
			priority if (keep1) begin
				body[0] = '{ch: held0_q, endm: 1'b0};
				body_n  = 3'd1;
				need_bs = kept_q;
			end else if (keep2) begin
				body[0] = '{ch: held0_q, endm: 1'b0};
				body[1] = '{ch: held1_q, endm: 1'b0};
				body_n  = 3'd2;
				need_bs = kept_q;
			end else begin
				body_n = 3'd0;
			end
		end else if (len_q == 2'd2) begin
			// third character: component is long enough to keep
			body[0] = '{ch: held0_q, endm: 1'b0};
			body[1] = '{ch: held1_q, endm: 1'b0};
			body[2] = '{ch: ch, endm: 1'b0};
			body_n  = 3'd3;
			need_bs = kept_q;
		end else if (len_q == 2'd3) begin
			body[0] = '{ch: ch, endm: 1'b0};
			body_n  = 3'd1;
		end
		n = body_n + {2'b0, need_bs};
		if (need_bs) begin
			sel = (idx_q == 2'd0) ? BS_ITEM : body[2'(idx_q - 2'd1)];
		end else begin
			sel = body[idx_q];
		end
	end

	assign active   = |pend;
	assign load_ok  = !out_vld_q || out_ready;
	assign step     = active && ((n == 3'd0) || load_ok);
	assign emit     = active && (n != 3'd0) && load_ok;
	assign last     = (n == 3'd0) || ({1'b0, idx_q} == 3'(n - 3'd1));
	assign ev_done  = step && last;
	assign ent_done = (pend & ~cur) == 3'b000;
	assign pop      = ev_done && ent_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= 2'd0;
			kept_q    <= 1'b0;
			idx_q     <= 2'd0;
			done_q    <= 3'b000;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (step) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (ev_done) begin
				done_q <= ent_done ? 3'b000 : (done_q | cur);
				priority if (cur[2]) begin
					len_q  <= 2'd0;
					kept_q <= 1'b0;
				end else if (is_sep) begin
					len_q  <= 2'd0;
					kept_q <= kept_q | keep1 | keep2;
				end else if (len_q == 2'd2) begin
					len_q  <= 2'd3;
					kept_q <= 1'b1;
				end else if (len_q != 2'd3) begin
					len_q <= len_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= sel;
		end
		if (ev_done && !cur[2] && !is_sep) begin
			if (len_q == 2'd0) begin
				held0_q <= ch;
			end
			if (len_q == 2'd1) begin
				held1_q <= ch;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign path_char = out_q.ch;
	assign end_mark  = out_q.endm;

endmodule

FILE: rtl/utf8_path_sanitizer_core.sv
// Top level of the UTF-8 archive entry name sanitiser.
//
// Input channel (in_valid/in_ready): one transaction per raw name byte,
// final_byte set on the last byte of a name. Output channel
// (out_valid/out_ready): one 16-bit path character per transaction; a
// transaction with end_mark set and path_char zero closes each name.
// The decoder front end takes one byte per cycle unless the queue is
// full, pushing decoded characters into a short queue; the component
// filter behind it issues one result per cycle from a registered output
// stage while the receiver is ready. A byte passes the queue and then
// the output register before its first result appears. Throughput: one
// byte per cycle while each byte yields at most one result; a byte that
// completes a third character, closes a component or ends the name
// yields up to six results and holds the filter until all are issued,
// the queue (QUEUE_DEPTH entries) absorbing the input meanwhile.
// Reset clears the decoder, queue, filter and output stage. When the
// receiver stalls the output register holds, the queue fills and
// in_ready falls once it is full.
module utf8_path_sanitizer_core import ups_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  name_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] path_char,
	output logic        end_mark
);

	push_t      push;
	entry_t     head;
	fifo_stat_t q_stat;
	logic       pop;

	// Decoder: UTF-8 sequences to characters, cut-short leads to '_'
	ups_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.name_byte  (name_byte),
		.final_byte (final_byte),
		.q_stat     (q_stat),
		.push       (push)
	);

	// Decouples the byte rate from the bursty result rate
	ups_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	// Component filter: drops empty, dot, dot-dot and drive components
	ups_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.path_char (path_char),
		.end_mark  (end_mark)
	);

	// The front end never offers a transaction to a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.vld && q_stat.full))
		else $error("push into full queue");

	// The filter never takes an entry from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("pop from empty queue");

	// The end marker always carries a zero character
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_mark) |-> (path_char == 16'h0000))
		else $error("end marker with non-zero character");

	// An accepted byte that ends a name always reaches the queue
	a_final_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && final_byte) |-> (push.vld && push.ent.fin))
		else $error("final byte not queued");

endmodule

FILE: tb/tb_utf8_path_sanitizer_core.sv
// Self-checking testbench for the UTF-8 path sanitiser core: directed table, then random names.
module tb_utf8_path_sanitizer_core import ups_pkg::*; ();

	// Clock, reset and DUT ports
	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  name_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] path_char;
	logic        end_mark;

	// 4 time unit period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	utf8_path_sanitizer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.name_byte  (name_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.path_char  (path_char),
		.end_mark   (end_mark)
	);

	// One row of the directed table. Rows with typed set carry their expected
	// characters (n of them, then the end marker); all other rows are checked
	// against the predictor.
	typedef struct packed {
		logic [7:0]  b;
		logic        fin;
		logic        typed;
		logic [1:0]  n;
		logic [15:0] c0;
		logic [15:0] c1;
	} dir_row_t;

	localparam int DIR_ROWS = 25;

	// Predictor state: decoder front end and component filter
	logic [7:0]  dec_lead;
	logic [7:0]  dec_follow;
	logic [1:0]  dec_need;
	logic        dec_held;
	logic [1:0]  comp_len;     // 3: component longer than two, already out
	logic [15:0] comp_chars [2];
	logic        comp_kept;

	out_item_t   step_out [$];       // characters caused by the current byte
	out_item_t   pending_chars [$];  // characters still owed by the DUT

	int          err_count = 0;
	bit          quiet = 1'b0;       // no idling on either side once set

	function automatic dir_row_t dir_row(input int i);
		dir_row_t r;
		case (i)
			// fresh state, single byte names: obvious results
			0:  r = {8'h61, 1'b1, 1'b1, 2'd1, 16'h0061, 16'h0000};
			1:  r = {8'hFF, 1'b1, 1'b1, 2'd1, CH_UNDERSCORE, 16'h0000};
			2:  r = {8'h00, 1'b1, 1'b1, 2'd1, 16'h0000, 16'h0000};  // NUL kept
			3:  r = {8'h2E, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000};  // "." dropped
			// ".." dropped, only the end marker remains
			4:  r = {8'h2E, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			5:  r = {8'h2E, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000};
			// drive letter dropped
			6:  r = {8'h43, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			7:  r = {8'h3A, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000};
			// leads cut short by the end of the name
			8:  r = {8'hC3, 1'b1, 1'b1, 2'd1, CH_UNDERSCORE, 16'h0000};
			9:  r = {8'hE2, 1'b1, 1'b1, 2'd1, CH_UNDERSCORE, 16'h0000};
			// three-byte lead whose first follower is final: reprocessed
			10: r = {8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			11: r = {8'h82, 1'b1, 1'b0, 2'd0, 16'h0000, 16'h0000};
			// four-byte lead, then separator closes a one char component
			12: r = {8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			13: r = {8'h2F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			// U+FFFF and U+07FF, closed by a backslash
			14: r = {8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			15: r = {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			16: r = {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			17: r = {8'hDF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			18: r = {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			19: r = {8'h5C, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			// long component streamed out char by char
			20: r = {8'h78, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			21: r = {8'h79, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			22: r = {8'h7A, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000};
			23: r = {8'h7F, 1'b1, 1'b0, 2'd0, 16'h0000, 16'h0000};
			// lowest stray byte
			default: r = {8'h80, 1'b1, 1'b1, 2'd1, CH_UNDERSCORE, 16'h0000};
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (err_count < 100)
			$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic book_char(input logic [15:0] ch, input logic endm);
		out_item_t it;
		it.ch = ch;
		it.endm = endm;
		pending_chars.insert(pending_chars.size(), it);
	endtask

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------
	task automatic emit_char(input logic [15:0] ch, input logic endm);
		out_item_t it;
		if (step_out.size() < 8) begin
			it.ch = ch;
			it.endm = endm;
			step_out.insert(step_out.size(), it);
		end
	endtask

	// backslash goes in front of every kept component but the first
	task automatic open_component();
		if (comp_kept)
			emit_char(CH_BACKSLASH, 1'b0);
		comp_kept = 1'b1;
	endtask

	task automatic close_component();
		logic drop;
		if (comp_len == 2'd1) begin
			if (comp_chars[0] != CH_DOT) begin
				open_component();
				emit_char(comp_chars[0], 1'b0);
			end
		end else if (comp_len == 2'd2) begin
			drop = (comp_chars[0] == CH_DOT && comp_chars[1] == CH_DOT) ||
				comp_chars[1] == CH_COLON;
			if (!drop) begin
				open_component();
				emit_char(comp_chars[0], 1'b0);
				emit_char(comp_chars[1], 1'b0);
			end
		end
		comp_len = 2'd0;
	endtask

	task automatic feed_char(input logic [15:0] c);
		if (c == CH_SLASH || c == CH_BACKSLASH) begin
			close_component();
		end else begin
			case (comp_len)
				2'd0: begin
					comp_chars[0] = c;
					comp_len = 2'd1;
				end
				2'd1: begin
					comp_chars[1] = c;
					comp_len = 2'd2;
				end
				2'd2: begin
					// third char: component can no longer be dropped
					open_component();
					emit_char(comp_chars[0], 1'b0);
					emit_char(comp_chars[1], 1'b0);
					emit_char(c, 1'b0);
					comp_len = 2'd3;
				end
				default: emit_char(c, 1'b0);
			endcase
		end
	endtask

	task automatic fresh_byte(input logic [7:0] b, input logic fin);
		if (b < 8'h80) begin
			feed_char({8'h00, b});
		end else if ((b & MASK_LEAD2) == CODE_LEAD2 && !fin) begin
			dec_lead = b;
			dec_need = 2'd1;
			dec_held = 1'b0;
		end else if ((b & MASK_LEAD3) == CODE_LEAD3 && !fin) begin
			dec_lead = b;
			dec_need = 2'd2;
			dec_held = 1'b0;
		end else begin
			feed_char(CH_UNDERSCORE);
		end
	endtask

	task automatic clear_state();
		dec_lead = 8'h00;
		dec_follow = 8'h00;
		dec_need = 2'd0;
		dec_held = 1'b0;
		comp_len = 2'd0;
		comp_chars[0] = 16'h0000;
		comp_chars[1] = 16'h0000;
		comp_kept = 1'b0;
	endtask

	// Works out every character one accepted byte causes, into step_out
	task automatic sanitise_byte(input logic [7:0] b, input logic fin);
		logic [15:0] c;
		step_out.delete();
		if (dec_need == 2'd0) begin
			fresh_byte(b, fin);
		end else if (dec_need == 2'd2) begin
			if (fin) begin
				// three-byte lead cut short: lead becomes '_', byte retried as final
				dec_need = 2'd0;
				feed_char(CH_UNDERSCORE);
				fresh_byte(b, 1'b1);
			end else begin
				dec_follow = b;
				dec_held = 1'b1;
				dec_need = 2'd1;
			end
		end else begin
			if (dec_held)
				c = {dec_lead[3:0], dec_follow[5:0], b[5:0]};
			else
				c = {5'b00000, dec_lead[4:0], b[5:0]};
			dec_need = 2'd0;
			dec_held = 1'b0;
			feed_char(c);
		end
		if (fin) begin
			close_component();
			emit_char(16'h0000, 1'b1);
			clear_state();
		end
	endtask

	// ---------------------------------------------------------------------
	// Input side: drive at the falling edge, accept at the rising edge
	// ---------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		name_byte  <= b;
		final_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Output side: random stall bursts on out_ready
	// ---------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// Every output transaction is checked against the oldest pending char
	always @(posedge clk) begin : chk_out
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				flag_mismatch($sformatf("transaction with nothing pending: char %h end %b",
					path_char, end_mark));
			end else begin
				want = pending_chars.pop_front();
				if (path_char !== want.ch)
					flag_mismatch($sformatf("path_char %h, expected %h", path_char, want.ch));
				if (end_mark !== want.endm)
					flag_mismatch($sformatf("end_mark %b, expected %b", end_mark, want.endm));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin : stim
		dir_row_t   r;
		logic [7:0] nb [$];
		logic [7:0] bv;
		int         sent;
		int         kind;
		int         len;
		int         tok;
		int         i;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		name_byte  = 8'h00;
		final_byte = 1'b0;
		clear_state();
		sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (i = 0; i < DIR_ROWS; i++) begin
			r = dir_row(i);
			send_byte(r.b, r.fin);
			sanitise_byte(r.b, r.fin);
			if (r.typed) begin
				if (r.n > 2'd0) book_char(r.c0, 1'b0);
				if (r.n > 2'd1) book_char(r.c1, 1'b0);
				book_char(16'h0000, 1'b1);
			end else begin
				foreach (step_out[k]) pending_chars.insert(pending_chars.size(), step_out[k]);
			end
		end

		// Random names: mostly well-formed tokens, some raw noise, some
		// names that end in the middle of a multibyte sequence
		while (sent < 285) begin
			nb.delete();
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					bv = 8'($urandom_range(0, 255));
					nb.insert(nb.size(), bv);
				end
			end else begin
				len = $urandom_range(1, 10);
				repeat (len) begin
					tok = $urandom_range(0, 99);
					if (tok < 30) begin
						bv = 8'h61 + 8'($urandom_range(0, 25));
						nb.insert(nb.size(), bv);
					end else if (tok < 36) begin
						nb.insert(nb.size(), 8'h2F);
					end else if (tok < 42) begin
						nb.insert(nb.size(), 8'h5C);
					end else if (tok < 52) begin
						nb.insert(nb.size(), 8'h2E);
					end else if (tok < 57) begin
						nb.insert(nb.size(), 8'h3A);
					end else if (tok < 67) begin
						bv = 8'hC0 | 8'($urandom_range(0, 31));
						nb.insert(nb.size(), bv);
						bv = 8'h80 | 8'($urandom_range(0, 63));
						nb.insert(nb.size(), bv);
					end else if (tok < 77) begin
						bv = 8'hE0 | 8'($urandom_range(0, 15));
						nb.insert(nb.size(), bv);
						bv = 8'h80 | 8'($urandom_range(0, 63));
						nb.insert(nb.size(), bv);
						bv = 8'h80 | 8'($urandom_range(0, 63));
						nb.insert(nb.size(), bv);
					end else if (tok < 82) begin
						bv = 8'hF0 | 8'($urandom_range(0, 15));
						nb.insert(nb.size(), bv);
					end else if (tok < 87) begin
						bv = 8'h80 | 8'($urandom_range(0, 63));
						nb.insert(nb.size(), bv);
					end else begin
						bv = 8'($urandom_range(0, 255));
						nb.insert(nb.size(), bv);
					end
				end
				if (kind >= 85) begin
					// broken tail
					case ($urandom_range(0, 2))
						0: begin
							bv = 8'hC0 | 8'($urandom_range(0, 31));
							nb.insert(nb.size(), bv);
						end
						1: begin
							bv = 8'hE0 | 8'($urandom_range(0, 15));
							nb.insert(nb.size(), bv);
						end
						default: begin
							bv = 8'hE0 | 8'($urandom_range(0, 15));
							nb.insert(nb.size(), bv);
							bv = 8'($urandom_range(0, 255));
							nb.insert(nb.size(), bv);
						end
					endcase
				end
			end

			// last stretch of the run goes at full rate on both sides
			if (sent >= 245)
				quiet = 1'b1;

			foreach (nb[k]) begin
				send_byte(nb[k], k == nb.size() - 1);
				sanitise_byte(nb[k], k == nb.size() - 1);
				foreach (step_out[m]) pending_chars.insert(pending_chars.size(), step_out[m]);
				sent++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then keep idling to catch any stray transaction
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: utf8_path_sanitizer_core.f
rtl/ups_pkg.sv
rtl/ups_fifo.sv
rtl/ups_front.sv
rtl/ups_back.sv
rtl/utf8_path_sanitizer_core.sv
tb/tb_utf8_path_sanitizer_core.sv
